/* rtl/sms_pkg.sv */
// ----------------------------------------------------------------------------
// sms_pkg
// Shared constants and types for the strand merge sorter.
// ----------------------------------------------------------------------------
package sms_pkg;

    localparam int IN_WIDTH = 32;

    localparam logic PH_LOAD  = 1'b0;
    localparam logic PH_DRAIN = 1'b1;

    typedef struct packed {
        logic insert;
        logic shift;
    } ctl_t;

endpackage

/* rtl/sms_if.sv */
// ----------------------------------------------------------------------------
// sms_in_if / sms_out_if
// Valid/ready channels for list elements going in and sorted results going out.
// ----------------------------------------------------------------------------
interface sms_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [sms_pkg::IN_WIDTH-1:0] value;
    logic                              is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface sms_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [sms_pkg::IN_WIDTH-1:0] sorted_value;
    logic                              last_out;
    logic                              overflow;

    modport source (output valid, output sorted_value, output last_out,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_value, input last_out,
                    input overflow, output ready);
endinterface

/* rtl/sms_cell.sv */
// ----------------------------------------------------------------------------
// sms_cell
// One slot of the sorted row: holds a value, takes part in insertion and
// shifts toward the head while draining.
// ----------------------------------------------------------------------------
module sms_cell #(
    parameter int W = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sms_pkg::ctl_t       ctl,
    input  logic signed [W-1:0] x,
    input  logic                prev_take,
    input  logic                prev_occ,
    input  logic signed [W-1:0] prev_val,
    input  logic                next_occ,
    input  logic signed [W-1:0] next_val,
    output logic signed [W-1:0] val,
    output logic                occ,
    output logic                take
);

    logic signed [W-1:0] val_reg;
    logic signed [W-1:0] val_next;
    logic                occ_reg;
    logic                occ_next;

    // x lands at or before this slot
    assign take = !occ_reg || (x < val_reg);
    assign val  = val_reg;
    assign occ  = occ_reg;

    always_comb
    begin
        val_next = val_reg;
        occ_next = occ_reg;
        if (ctl.shift)
        begin
            val_next = next_val;
            occ_next = next_occ;
        end
        else if (ctl.insert)
        begin
            occ_next = occ_reg | prev_occ;
            if (take)
            begin
                val_next = prev_take ? prev_val : x;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

/* rtl/sms_chain.sv */
// ----------------------------------------------------------------------------
// sms_chain
// Row of sorting cells; smallest value sits at the head.
// ----------------------------------------------------------------------------
module sms_chain #(
    parameter int N = 64,
    parameter int W = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sms_pkg::ctl_t       ctl,
    input  logic signed [W-1:0] x,
    output logic signed [W-1:0] head
);

    logic signed [W-1:0] val  [N];
    logic                occ  [N];
    logic                take [N];

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            logic                p_take;
            logic                p_occ;
            logic signed [W-1:0] p_val;
            logic                n_occ;
            logic signed [W-1:0] n_val;

            if (i == 0)
            begin : g_first
                assign p_take = 1'b0;
                assign p_occ  = 1'b1;
                assign p_val  = x;
            end
            else
            begin : g_mid
                assign p_take = take[i-1];
                assign p_occ  = occ[i-1];
                assign p_val  = val[i-1];
            end

            if (i == N - 1)
            begin : g_last
                assign n_occ = 1'b0;
                assign n_val = x;
            end
            else
            begin : g_inner
                assign n_occ = occ[i+1];
                assign n_val = val[i+1];
            end

            sms_cell #(.W(W)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .x         (x),
                .prev_take (p_take),
                .prev_occ  (p_occ),
                .prev_val  (p_val),
                .next_occ  (n_occ),
                .next_val  (n_val),
                .val       (val[i]),
                .occ       (occ[i]),
                .take      (take[i])
            );
        end
    endgenerate

    assign head = val[0];

endmodule

/* rtl/strand_merge_sorter.sv */
// ----------------------------------------------------------------------------
// strand_merge_sorter
// Collects a list of signed values and returns it in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   items   : one request per list element; is_last closes the batch.
//   results : one request per sorted element; last_out marks the final one,
//             overflow flags a batch that had more than MAX_LEN elements.
// Each element is written into the cell row on acceptance; every cell compares it
// with its own value and the row opens a gap by shifting one slot right.
// After is_last, items.ready is low while the row drains from its head at
// one result per cycle while the receiver is ready. Once the last element
// is taken, the phase register turns to draining and the head then loads
// into the output register as the first result. Elements beyond MAX_LEN
// are dropped. A stalled receiver freezes the drain; the output register
// holds the pending result. Loading of the next batch starts once the last
// result is in the output register, even if it has not yet been taken.
// Reset empties the row and clears the output valid and overflow flags.
// ----------------------------------------------------------------------------
module strand_merge_sorter #(
    parameter int MAX_LEN    = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    sms_in_if.sink    items,
    sms_out_if.source results
);

    localparam int EW = (DATA_WIDTH > sms_pkg::IN_WIDTH) ? sms_pkg::IN_WIDTH
                                                          : DATA_WIDTH;
    localparam int CW = $clog2(MAX_LEN + 1);

    logic                             phase_reg;
    logic                             phase_next;
    logic [CW-1:0]                    count_reg;
    logic [CW-1:0]                    count_next;
    logic                             ovf_reg;
    logic                             ovf_next;
    logic                             ovalid_reg;
    logic                             ovalid_next;
    logic signed [sms_pkg::IN_WIDTH-1:0] odata_reg;
    logic                             olast_reg;
    logic                             oovf_reg;

    sms_pkg::ctl_t                    ctl;
    logic signed [EW-1:0]             x;
    logic signed [EW-1:0]             head;
    logic                             accept;
    logic                             room;
    logic                             pop;

    assign items.ready = (phase_reg == sms_pkg::PH_LOAD);
    assign accept      = items.valid && items.ready;
    assign room        = (count_reg < CW'(MAX_LEN));
    assign x           = items.value[EW-1:0];
    assign pop         = (phase_reg == sms_pkg::PH_DRAIN) && (count_reg != '0)
                         && (!ovalid_reg || results.ready);

    assign ctl.insert = accept && room;
    assign ctl.shift  = pop;

    sms_chain #(.N(MAX_LEN), .W(EW)) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .x     (x),
        .head  (head)
    );

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        ovalid_next = ovalid_reg;
        if (results.ready)
        begin
            ovalid_next = 1'b0;
        end
        unique case (phase_reg)
            sms_pkg::PH_LOAD:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (items.is_last)
                    begin
                        phase_next = sms_pkg::PH_DRAIN;
                    end
                end
            end
            sms_pkg::PH_DRAIN:
            begin
                if (pop)
                begin
                    ovalid_next = 1'b1;
                    count_next  = count_reg - 1'b1;
                    if (count_reg == CW'(1))
                    begin
                        phase_next = sms_pkg::PH_LOAD;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                phase_next = sms_pkg::PH_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= sms_pkg::PH_LOAD;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            odata_reg <= sms_pkg::IN_WIDTH'(head);
            olast_reg <= (count_reg == CW'(1));
            oovf_reg  <= ovf_reg;
        end
    end

    assign results.valid        = ovalid_reg;
    assign results.sorted_value = odata_reg;
    assign results.last_out     = olast_reg;
    assign results.overflow     = oovf_reg;

    // Element count never exceeds the row length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_LEN))
        else $error("element count exceeds capacity");

    // Draining only with elements left in the row
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == sms_pkg::PH_DRAIN) |-> (count_reg != '0))
        else $error("drain phase with empty row");

    // Closing element moves the block into draining
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && items.is_last) |=> (phase_reg == sms_pkg::PH_DRAIN))
        else $error("batch end did not start drain");

    // The final result of a batch returns the block to loading
    a_last_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (count_reg == CW'(1))) |=> (phase_reg == sms_pkg::PH_LOAD))
        else $error("final result did not end drain");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Sends lists of signed values to strand_merge_sorter and checks that each
// list returns in ascending order, with the last marker on the final result
// and the overflow flag on every result of a list longer than MAX_LEN.
// A few short directed lists come first, then random lists with random
// handshake gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_LEN           = 64;
    localparam int ELEM_W            = sms_pkg::IN_WIDTH;
    localparam int RANDOM_ITEMS      = 100;
    localparam int LONG_STALL_AT     = 40;
    localparam int LONG_STALL_CYCLES = 300;
    localparam int DRAIN_CYCLES      = 12;
    localparam int CYCLE_LIMIT       = 100000;

    typedef struct {
        logic signed [ELEM_W-1:0] value;
        logic                     is_last;
        bit                       drain_first;
    } elem_req_t;

    typedef struct {
        logic signed [ELEM_W-1:0] value;
        logic                     last_out;
        logic                     overflow;
    } sorted_res_t;

    typedef enum int {
        PAT_RANDOM,
        PAT_NARROW,
        PAT_EXTREME,
        PAT_RISING,
        PAT_FALLING
    } val_pattern_t;

    logic clk;
    logic rst_n;

    sms_in_if  elem_ch ();
    sms_out_if sorted_ch ();

    strand_merge_sorter #(
        .MAX_LEN    (MAX_LEN),
        .DATA_WIDTH (ELEM_W)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (elem_ch),
        .results (sorted_ch)
    );

    elem_req_t   pending_elems [$];
    sorted_res_t sorted_expect [$];

    // list being collected by the predictor
    logic signed [ELEM_W-1:0] list_buf [MAX_LEN];
    int                       list_len;
    bit                       list_ovf;

    bit elem_taken;
    bit elem_burst;
    int elem_gap;
    bit sorted_taken;
    bit sorted_taken_last;
    bit sorted_burst;
    int sorted_gap;
    int results_seen;
    int mismatches;
    int cycle_cnt;

    always #1 clk = ~clk;

    // predictor: collect one element, sort and post the list on the last one
    task automatic take_element(logic signed [ELEM_W-1:0] v, logic last);
        logic signed [ELEM_W-1:0] key;
        sorted_res_t              res;
        int                       i;
        int                       j;
        if (list_len < MAX_LEN)
        begin
            list_buf[list_len] = v;
            list_len++;
        end
        else
            list_ovf = 1'b1;
        if (last)
        begin
            for (i = 1; i < list_len; i++)
            begin
                key = list_buf[i];
                j   = i - 1;
                while (j >= 0 && list_buf[j] > key)
                begin
                    list_buf[j+1] = list_buf[j];
                    j--;
                end
                list_buf[j+1] = key;
            end
            for (i = 0; i < list_len; i++)
            begin
                res.value    = list_buf[i];
                res.last_out = (i == list_len - 1);
                res.overflow = list_ovf;
                sorted_expect.push_back(res);
            end
            list_len = 0;
            list_ovf = 1'b0;
        end
    endtask

    task automatic add_elem(logic signed [ELEM_W-1:0] v, logic last, bit drain_first);
        elem_req_t req;
        req.value       = v;
        req.is_last     = last;
        req.drain_first = drain_first;
        pending_elems.push_back(req);
    endtask

    task automatic queue_list(int n, val_pattern_t pattern, bit drain_first);
        logic signed [ELEM_W-1:0] base;
        logic signed [ELEM_W-1:0] step;
        logic signed [ELEM_W-1:0] v;
        int                       k;
        base = $urandom;
        step = $urandom_range(0, 1000);
        for (k = 0; k < n; k++)
        begin
            case (pattern)
                PAT_NARROW:  v = $signed($urandom_range(0, 16)) - 8;
                PAT_EXTREME:
                    case ($urandom_range(0, 4))
                        0:       v = 32'h8000_0000;
                        1:       v = 32'h7fff_ffff;
                        2:       v = 0;
                        3:       v = -1;
                        default: v = $urandom;
                    endcase
                PAT_RISING:  v = base + k * step;
                PAT_FALLING: v = base - k * step;
                default:     v = $urandom;
            endcase
            add_elem(v, k == n - 1, drain_first && k == 0);
        end
    endtask

    // input side: acceptance and prediction
    always @(posedge clk)
    begin
        if (rst_n && elem_ch.valid && elem_ch.ready)
        begin
            elem_taken = 1'b1;
            take_element(elem_ch.value, elem_ch.is_last);
        end
    end

    // input side: driver
    always @(negedge clk)
    begin : drive_elems
        logic      nxt_valid;
        elem_req_t req;
        nxt_valid = elem_ch.valid;
        if (elem_taken)
        begin
            elem_taken = 1'b0;
            nxt_valid  = 1'b0;
            if (elem_ch.is_last)
                elem_burst = ($urandom_range(0, 3) == 0);
            elem_gap = elem_burst ? 0 : $urandom_range(0, 4);
        end
        if (rst_n && !nxt_valid)
        begin
            if (elem_gap > 0)
                elem_gap--;
            else if (pending_elems.size() > 0 &&
                     !(pending_elems[0].drain_first && sorted_expect.size() > 0))
            begin
                req = pending_elems.pop_front();
                elem_ch.value   <= req.value;
                elem_ch.is_last <= req.is_last;
                nxt_valid = 1'b1;
            end
        end
        elem_ch.valid <= nxt_valid;
    end

    // output side: monitor and checker
    always @(posedge clk)
    begin : check_results
        sorted_res_t exp_res;
        if (rst_n && sorted_ch.valid && sorted_ch.ready)
        begin
            sorted_taken      = 1'b1;
            sorted_taken_last = sorted_ch.last_out;
            results_seen++;
            if (sorted_expect.size() == 0)
            begin
                $error("unexpected request: sorted_value %0d", sorted_ch.sorted_value);
                mismatches++;
            end
            else
            begin
                exp_res = sorted_expect.pop_front();
                if (sorted_ch.sorted_value !== exp_res.value)
                begin
                    $error("sorted_value: expected %0d, actual %0d",
                           exp_res.value, sorted_ch.sorted_value);
                    mismatches++;
                end
                if (sorted_ch.last_out !== exp_res.last_out)
                begin
                    $error("last_out: expected %0b, actual %0b",
                           exp_res.last_out, sorted_ch.last_out);
                    mismatches++;
                end
                if (sorted_ch.overflow !== exp_res.overflow)
                begin
                    $error("overflow: expected %0b, actual %0b",
                           exp_res.overflow, sorted_ch.overflow);
                    mismatches++;
                end
            end
        end
    end

    // output side: ready with random stalls, one long hold-off mid-list
    always @(negedge clk)
    begin : drive_ready
        logic nxt_ready;
        nxt_ready = sorted_ch.ready;
        if (sorted_taken)
        begin
            sorted_taken = 1'b0;
            nxt_ready    = 1'b0;
            if (sorted_taken_last)
                sorted_burst = ($urandom_range(0, 3) == 0);
            sorted_gap = sorted_burst ? 0 : $urandom_range(0, 4);
            if (results_seen == LONG_STALL_AT)
                sorted_gap = LONG_STALL_CYCLES;
        end
        if (rst_n && !nxt_ready)
        begin
            if (sorted_gap > 0)
                sorted_gap--;
            else
                nxt_ready = 1'b1;
        end
        sorted_ch.ready <= nxt_ready;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int random_items;
        int list_no;
        int n;

        clk               = 1'b0;
        rst_n             = 1'b0;
        elem_ch.valid     = 1'b0;
        elem_ch.value     = '0;
        elem_ch.is_last   = 1'b0;
        sorted_ch.ready   = 1'b0;
        elem_taken        = 1'b0;
        elem_burst        = 1'b0;
        elem_gap          = 0;
        sorted_taken      = 1'b0;
        sorted_taken_last = 1'b0;
        sorted_burst      = 1'b0;
        sorted_gap        = $urandom_range(0, 4);
        results_seen      = 0;
        mismatches        = 0;
        cycle_cnt         = 0;
        list_len          = 0;
        list_ovf          = 1'b0;

        // single-element lists at both extremes
        add_elem(32'sh7fff_ffff, 1'b1, 1'b0);
        add_elem(32'sh8000_0000, 1'b1, 1'b0);
        // extremes mixed with values around zero
        add_elem(32'sh8000_0000, 1'b0, 1'b0);
        add_elem(32'sh7fff_ffff, 1'b0, 1'b0);
        add_elem(-1, 1'b0, 1'b0);
        add_elem(0, 1'b0, 1'b0);
        add_elem(1, 1'b1, 1'b0);
        // strictly descending: every strand has one element
        add_elem(5, 1'b0, 1'b0);
        add_elem(4, 1'b0, 1'b0);
        add_elem(3, 1'b0, 1'b0);
        add_elem(2, 1'b0, 1'b0);
        add_elem(-2, 1'b1, 1'b0);
        // duplicates
        add_elem(3, 1'b0, 1'b0);
        add_elem(3, 1'b0, 1'b0);
        add_elem(-3, 1'b0, 1'b0);
        add_elem(3, 1'b0, 1'b0);
        add_elem(-3, 1'b1, 1'b0);
        // already sorted: one strand
        add_elem(-2, 1'b0, 1'b1);
        add_elem(-1, 1'b0, 1'b0);
        add_elem(0, 1'b0, 1'b0);
        add_elem(1, 1'b0, 1'b0);
        add_elem(2, 1'b1, 1'b0);

        // random lists; one exactly full, one overflowing (last dropped too)
        random_items = 0;
        list_no      = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (list_no == 1)
                n = MAX_LEN;
            else if (list_no == 3)
                n = MAX_LEN + $urandom_range(1, 3);
            else
                n = $urandom_range(1, 10);
            queue_list(n, val_pattern_t'($urandom_range(0, 4)),
                       list_no == 2 || $urandom_range(0, 9) == 0);
            random_items += n;
            list_no++;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_elems.size() != 0 || elem_ch.valid)
            @(posedge clk);
        while (sorted_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
